### rtl/sct_pkg.sv
// ---------------------------------------------------------------------------
// sct_pkg
// Shared types and codes for the source character tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;

  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [COLUMN_BITS-1:0] col_t;

  typedef enum logic [3:0] {
    M_IDLE, M_INT, M_FRAC0, M_FRAC, M_EXP0, M_EXPS, M_EXP,
    M_STR, M_ESC, M_NAME, M_OP, M_ERR
  } mode_t;

  localparam logic [1:0] EV_TEXT  = 2'd0;
  localparam logic [1:0] EV_DONE  = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  localparam logic [4:0] KIND_INT     = 5'd0;
  localparam logic [4:0] KIND_FLOAT   = 5'd1;
  localparam logic [4:0] KIND_STRING  = 5'd2;
  localparam logic [4:0] KIND_NAME    = 5'd3;
  localparam logic [4:0] KIND_END     = 5'd4;
  localparam logic [4:0] KIND_GE      = 5'd5;
  localparam logic [4:0] KIND_LE      = 5'd6;
  localparam logic [4:0] KIND_EQ      = 5'd7;
  localparam logic [4:0] KIND_NE      = 5'd8;
  localparam logic [4:0] KIND_OP_BASE = 5'd9;

  localparam logic [2:0] ERR_BAD_CHAR   = 3'd0;
  localparam logic [2:0] ERR_BAD_FRAC   = 3'd1;
  localparam logic [2:0] ERR_BAD_EXP    = 3'd2;
  localparam logic [2:0] ERR_LONE_BANG  = 3'd3;
  localparam logic [2:0] ERR_BAD_ESC    = 3'd4;
  localparam logic [2:0] ERR_ESC_AT_END = 3'd5;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [4:0]  token_kind;
    logic [7:0]  text_char;
    logic [15:0] line;
    logic [15:0] column;
    logic [2:0]  error_code;
    logic        last;
  } res_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] pend_op;
    line_t      start_line;
    col_t       start_col;
    line_t      cur_line;
    col_t       cur_col;
  } scan_t;

endpackage

`default_nettype wire

### rtl/sct_in_if.sv
// ---------------------------------------------------------------------------
// sct_in_if
// Source byte channel: one character or end marker per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface sct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

### rtl/sct_out_if.sv
// ---------------------------------------------------------------------------
// sct_out_if
// Token event channel: text characters, completions and errors.
// ---------------------------------------------------------------------------
`default_nettype none

interface sct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [4:0]  token_kind;
  logic [7:0]  text_char;
  logic [15:0] line;
  logic [15:0] column;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, output event_res, output token_kind, output text_char,
                  output line, output column, output error_code, output last,
                  input ready);
  modport sink   (input valid, input event_res, input token_kind, input text_char,
                  input line, input column, input error_code, input last,
                  output ready);
endinterface

`default_nettype wire

### rtl/sct_step.sv
// ---------------------------------------------------------------------------
// sct_step
// Next scanner state and up to two events for one source byte.
// ---------------------------------------------------------------------------
`default_nettype none

module sct_step (
  input  sct_pkg::scan_t cur,
  input  logic [7:0]     char_code,
  input  logic           end_of_input,
  output sct_pkg::scan_t nxt,
  output sct_pkg::res_t  res0,
  output sct_pkg::res_t  res1,
  output logic [1:0]     res_cnt
);
  import sct_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_USCR  = 8'h5F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_LT_T  = 8'h74;
  localparam logic [7:0] CH_LV    = 8'h76;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  function automatic logic is_dig(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [4:0] op_kind(logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      CH_EQ:    k = KIND_OP_BASE + 5'd0;
      CH_PLUS:  k = KIND_OP_BASE + 5'd1;
      CH_MINUS: k = KIND_OP_BASE + 5'd2;
      CH_STAR:  k = KIND_OP_BASE + 5'd3;
      CH_SLASH: k = KIND_OP_BASE + 5'd4;
      CH_PCT:   k = KIND_OP_BASE + 5'd5;
      CH_GT:    k = KIND_OP_BASE + 5'd6;
      CH_LT:    k = KIND_OP_BASE + 5'd7;
      CH_LBRC:  k = KIND_OP_BASE + 5'd8;
      CH_RBRC:  k = KIND_OP_BASE + 5'd9;
      CH_LBRK:  k = KIND_OP_BASE + 5'd10;
      CH_RBRK:  k = KIND_OP_BASE + 5'd11;
      CH_LPAR:  k = KIND_OP_BASE + 5'd12;
      CH_RPAR:  k = KIND_OP_BASE + 5'd13;
      CH_DOT:   k = KIND_OP_BASE + 5'd14;
      CH_COMMA: k = KIND_OP_BASE + 5'd15;
      CH_SEMI:  k = KIND_OP_BASE + 5'd16;
      CH_COLON: k = KIND_OP_BASE + 5'd17;
      default:  k = KIND_INT;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] pair_kind(logic [7:0] p);
    logic [4:0] k;
    priority case (p)
      CH_GT:   k = KIND_GE;
      CH_LT:   k = KIND_LE;
      CH_EQ:   k = KIND_EQ;
      default: k = KIND_NE;
    endcase
    return k;
  endfunction

  // valid flag and translated byte
  function automatic logic [8:0] esc_val(logic [7:0] c);
    logic [8:0] v;
    unique case (c)
      CH_LA:   v = {1'b1, 8'd7};
      CH_LB:   v = {1'b1, 8'd8};
      CH_LF:   v = {1'b1, 8'd12};
      CH_LN:   v = {1'b1, 8'd10};
      CH_LR:   v = {1'b1, 8'd13};
      CH_LT_T: v = {1'b1, 8'd9};
      CH_LV:   v = {1'b1, 8'd11};
      CH_BSL:  v = {1'b1, CH_BSL};
      CH_DQ:   v = {1'b1, CH_DQ};
      CH_QM:   v = {1'b1, CH_QM};
      CH_0:    v = {1'b1, 8'd0};
      default: v = {1'b0, 8'd0};
    endcase
    return v;
  endfunction

  function automatic res_t mk(logic [1:0] ev, logic [4:0] kind, logic [7:0] ch,
                              line_t ln, col_t col, logic [2:0] err);
    res_t       r;
    logic [31:0] wl;
    logic [31:0] wc;
    wl = 32'(ln);
    wc = 32'(col);
    r.event_res  = ev;
    r.token_kind = kind;
    r.text_char  = ch;
    r.line       = wl[15:0];
    r.column     = wc[15:0];
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

  logic [7:0] c;
  line_t      adv_line;
  col_t       adv_col;
  logic       is_opc;
  logic       pend_pairs;

  assign c          = char_code;
  assign is_opc     = c == CH_BANG || op_kind(c) != KIND_INT;
  assign pend_pairs = cur.pend_op == CH_GT || cur.pend_op == CH_LT ||
                      cur.pend_op == CH_EQ || cur.pend_op == CH_BANG;

  // position after this byte, saturating
  always_comb begin
    adv_line = cur.cur_line;
    adv_col  = cur.cur_col;
    if (c == CH_NL) begin
      if (cur.cur_line != '1) adv_line = cur.cur_line + line_t'(1);
      adv_col = col_t'(1);
    end else if (cur.cur_col != '1) begin
      adv_col = cur.cur_col + col_t'(1);
    end
  end

  always_comb begin
    res_t       rr [2];
    logic [1:0] n;
    logic       do_adv;
    logic       call_st;
    logic [8:0] ev;

    rr[0]   = '0;
    rr[1]   = '0;
    n       = 2'd0;
    do_adv  = 1'b0;
    call_st = 1'b0;
    nxt     = cur;
    ev      = esc_val(c);

    if (end_of_input) begin
      unique case (cur.mode)
        M_INT: begin
          rr[n[0]] = mk(EV_DONE, KIND_INT, 8'd0, cur.start_line, cur.start_col, 3'd0);
          n = n + 2'd1;
        end
        M_FRAC, M_EXP: begin
          rr[n[0]] = mk(EV_DONE, KIND_FLOAT, 8'd0, cur.start_line, cur.start_col, 3'd0);
          n = n + 2'd1;
        end
        M_STR: begin
          rr[n[0]] = mk(EV_DONE, KIND_STRING, 8'd0, cur.start_line, cur.start_col, 3'd0);
          n = n + 2'd1;
        end
        M_NAME: begin
          rr[n[0]] = mk(EV_DONE, KIND_NAME, 8'd0, cur.start_line, cur.start_col, 3'd0);
          n = n + 2'd1;
        end
        M_FRAC0: begin
          rr[n[0]] = mk(EV_ERROR, KIND_INT, 8'd0, cur.cur_line, cur.cur_col, ERR_BAD_FRAC);
          n = n + 2'd1;
        end
        M_EXP0, M_EXPS: begin
          rr[n[0]] = mk(EV_ERROR, KIND_INT, 8'd0, cur.cur_line, cur.cur_col, ERR_BAD_EXP);
          n = n + 2'd1;
        end
        M_ESC: begin
          rr[n[0]] = mk(EV_ERROR, KIND_INT, 8'd0, cur.cur_line, cur.cur_col,
                        ERR_ESC_AT_END);
          n = n + 2'd1;
        end
        M_OP: begin
          if (cur.pend_op == CH_BANG) begin
            rr[n[0]] = mk(EV_ERROR, KIND_INT, 8'd0, cur.cur_line, cur.cur_col,
                          ERR_LONE_BANG);
          end else begin
            rr[n[0]] = mk(EV_DONE, op_kind(cur.pend_op), 8'd0, cur.start_line,
                          cur.start_col, 3'd0);
          end
          n = n + 2'd1;
        end
        default: ;
      endcase
      rr[n[0]] = mk(EV_DONE, KIND_END, 8'd0, cur.cur_line, cur.cur_col, 3'd0);
      n = n + 2'd1;
      nxt.mode       = M_IDLE;
      nxt.pend_op    = 8'd0;
      nxt.start_line = line_t'(1);
      nxt.start_col  = col_t'(1);
      nxt.cur_line   = line_t'(1);
      nxt.cur_col    = col_t'(1);
    end else begin
      unique case (cur.mode)
        M_ERR: ;
        M_STR: begin
          do_adv = 1'b1;
          if (c == CH_DQ) begin
            rr[n[0]] = mk(EV_DONE, KIND_STRING, 8'd0, cur.start_line, cur.start_col, 3'd0);
            n = n + 2'd1;
            nxt.mode = M_IDLE;
          end else if (c == CH_BSL) begin
            nxt.mode = M_ESC;
          end else begin
            rr[n[0]] = mk(EV_TEXT, KIND_INT, c, cur.start_line, cur.start_col, 3'd0);
            n = n + 2'd1;
          end
        end
        M_ESC: begin
          do_adv = 1'b1;
          if (!ev[8]) begin
            rr[n[0]] = mk(EV_ERROR, KIND_INT, 8'd0, adv_line, adv_col, ERR_BAD_ESC);
            n = n + 2'd1;
            nxt.mode = M_ERR;
          end else begin
            rr[n[0]] = mk(EV_TEXT, KIND_INT, ev[7:0], cur.start_line, cur.start_col, 3'd0);
            n = n + 2'd1;
            nxt.mode = M_STR;
          end
        end
        M_INT, M_FRAC, M_EXP, M_NAME: begin
          if (is_dig(c) || (cur.mode == M_NAME && (is_alpha(c) || c == CH_USCR))) begin
            do_adv = 1'b1;
          end else if (cur.mode == M_INT && c == CH_DOT) begin
            do_adv   = 1'b1;
            nxt.mode = M_FRAC0;
          end else if ((cur.mode == M_INT || cur.mode == M_FRAC) &&
                       (c == CH_LE || c == CH_UE)) begin
            do_adv   = 1'b1;
            nxt.mode = M_EXP0;
          end else begin
            call_st = 1'b1;
          end
          if (do_adv) begin
            rr[n[0]] = mk(EV_TEXT, KIND_INT, c, cur.start_line, cur.start_col, 3'd0);
            n = n + 2'd1;
          end else begin
            priority case (cur.mode)
              M_INT:  rr[n[0]] = mk(EV_DONE, KIND_INT, 8'd0, cur.start_line,
                                    cur.start_col, 3'd0);
              M_NAME: rr[n[0]] = mk(EV_DONE, KIND_NAME, 8'd0, cur.start_line,
                                    cur.start_col, 3'd0);
              default: rr[n[0]] = mk(EV_DONE, KIND_FLOAT, 8'd0, cur.start_line,
                                     cur.start_col, 3'd0);
            endcase
            n = n + 2'd1;
          end
        end
        M_FRAC0, M_EXP0, M_EXPS: begin
          if (is_dig(c)) begin
            do_adv   = 1'b1;
            nxt.mode = (cur.mode == M_FRAC0) ? M_FRAC : M_EXP;
          end else if (cur.mode == M_EXP0 && (c == CH_PLUS || c == CH_MINUS)) begin
            do_adv   = 1'b1;
            nxt.mode = M_EXPS;
          end
          if (do_adv) begin
            rr[n[0]] = mk(EV_TEXT, KIND_INT, c, cur.start_line, cur.start_col, 3'd0);
          end else begin
            rr[n[0]] = mk(EV_ERROR, KIND_INT, 8'd0, cur.cur_line, cur.cur_col,
                          (cur.mode == M_FRAC0) ? ERR_BAD_FRAC : ERR_BAD_EXP);
            nxt.mode = M_ERR;
          end
          n = n + 2'd1;
        end
        M_OP: begin
          if (c == CH_EQ && pend_pairs) begin
            do_adv = 1'b1;
            rr[n[0]] = mk(EV_TEXT, KIND_INT, c, cur.start_line, cur.start_col, 3'd0);
            n = n + 2'd1;
            rr[n[0]] = mk(EV_DONE, pair_kind(cur.pend_op), 8'd0, cur.start_line,
                          cur.start_col, 3'd0);
            n = n + 2'd1;
            nxt.mode = M_IDLE;
          end else if (cur.pend_op == CH_BANG) begin
            rr[n[0]] = mk(EV_ERROR, KIND_INT, 8'd0, cur.cur_line, cur.cur_col,
                          ERR_LONE_BANG);
            n = n + 2'd1;
            nxt.mode = M_ERR;
          end else begin
            rr[n[0]] = mk(EV_DONE, op_kind(cur.pend_op), 8'd0, cur.start_line,
                          cur.start_col, 3'd0);
            n = n + 2'd1;
            call_st = 1'b1;
          end
        end
        default: call_st = 1'b1;
      endcase

      // start of a new token at the current position
      if (call_st) begin
        nxt.mode = M_IDLE;
        if (is_space(c)) begin
          do_adv = 1'b1;
        end else begin
          nxt.start_line = cur.cur_line;
          nxt.start_col  = cur.cur_col;
          if (is_dig(c) || is_alpha(c) || c == CH_USCR || is_opc) begin
            rr[n[0]] = mk(EV_TEXT, KIND_INT, c, cur.cur_line, cur.cur_col, 3'd0);
            do_adv   = 1'b1;
            if (is_dig(c)) begin
              nxt.mode = M_INT;
            end else if (is_opc) begin
              nxt.mode    = M_OP;
              nxt.pend_op = c;
            end else begin
              nxt.mode = M_NAME;
            end
            n = n + 2'd1;
          end else if (c == CH_DQ) begin
            do_adv   = 1'b1;
            nxt.mode = M_STR;
          end else begin
            rr[n[0]] = mk(EV_ERROR, KIND_INT, 8'd0, cur.cur_line, cur.cur_col,
                          ERR_BAD_CHAR);
            n = n + 2'd1;
            nxt.mode = M_ERR;
          end
        end
      end

      if (do_adv) begin
        nxt.cur_line = adv_line;
        nxt.cur_col  = adv_col;
      end
    end

    if (n == 2'd1) rr[0].last = 1'b1;
    if (n == 2'd2) rr[1].last = 1'b1;
    res0    = rr[0];
    res1    = rr[1];
    res_cnt = n;
  end

endmodule

`default_nettype wire

### rtl/source_char_tokenizer.sv
// ---------------------------------------------------------------------------
// source_char_tokenizer
// Streaming lexer: source bytes in, token text, completions and errors out.
// ---------------------------------------------------------------------------
//   channel   direction  carries
//   in_ch     sink       char_code, end_of_input
//   out_ch    source     event_res, token_kind, text_char, line, column,
//                        error_code, last
//
// a byte is scanned in the cycle it is taken; its events land in a two-entry
// result buffer and leave one per cycle while out_ch.ready is high (the
// buffer's single output port sets this rate)
// in_ch.ready is held low while the buffer still has more than one event to
// send, or one event that is not being taken
// synchronous active-low reset returns the scanner to idle at line 1, column 1
// ---------------------------------------------------------------------------
`default_nettype none

module source_char_tokenizer (
  input  logic      clk,
  input  logic      rst_n,
  sct_in_if.sink    in_ch,
  sct_out_if.source out_ch
);
  import sct_pkg::*;

  scan_t      scan_r;
  scan_t      scan_nxt;
  res_t       res0;
  res_t       res1;
  logic [1:0] res_cnt;
  res_t       q_r [2];
  logic [1:0] cnt_r;
  logic       take;
  logic       pop;

  sct_step u_step (
    .cur          (scan_r),
    .char_code    (in_ch.char_code),
    .end_of_input (in_ch.end_of_input),
    .nxt          (scan_nxt),
    .res0         (res0),
    .res1         (res1),
    .res_cnt      (res_cnt)
  );

  assign in_ch.ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ch.ready);
  assign take        = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.mode       <= M_IDLE;
      scan_r.pend_op    <= 8'd0;
      scan_r.start_line <= line_t'(1);
      scan_r.start_col  <= col_t'(1);
      scan_r.cur_line   <= line_t'(1);
      scan_r.cur_col    <= col_t'(1);
      cnt_r             <= 2'd0;
    end else begin
      if (take) begin
        scan_r <= scan_nxt;
        cnt_r  <= res_cnt;
      end else if (pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // buffer is empty, or drains this cycle, whenever a byte is taken
  always_ff @(posedge clk) begin
    if (take) begin
      q_r[0] <= res0;
      q_r[1] <= res1;
    end else if (pop) begin
      q_r[0] <= q_r[1];
    end
  end

  assign out_ch.valid      = cnt_r != 2'd0;
  assign out_ch.event_res  = q_r[0].event_res;
  assign out_ch.token_kind = q_r[0].token_kind;
  assign out_ch.text_char  = q_r[0].text_char;
  assign out_ch.line       = q_r[0].line;
  assign out_ch.column     = q_r[0].column;
  assign out_ch.error_code = q_r[0].error_code;
  assign out_ch.last       = q_r[0].last;

endmodule

`default_nettype wire

### sim/sct_checker.sv
// ---------------------------------------------------------------------------
// sct_checker
// Watches both channels of the tokenizer. Every source item taken is run
// through a cycle-free model of the scanner, and the events it should cause
// are queued. Every event the block delivers is compared field by field with
// the oldest queued one.
// ---------------------------------------------------------------------------
module sct_checker (
  input  logic clk,
  input  logic rst_n,
  sct_in_if    in_mon,
  sct_out_if   out_mon,
  output int   mismatch_count,
  output int   pending_events
);
  timeunit 1ns;
  timeprecision 1ps;

  import sct_pkg::*;

  localparam logic [4:0] NO_KIND  = 5'd0;
  localparam logic [2:0] NO_ERROR = 3'd0;

  mode_t      scan_mode_q;
  logic [7:0] pend_op;
  line_t      start_ln;
  line_t      cur_ln;
  col_t       start_col;
  col_t       cur_col;

  res_t step_ev [2];
  int   step_n;
  res_t token_events_due [$];
  res_t head_event;
  int   fault_total;
  int   events_seen;

  function automatic void reset_scanner();
    scan_mode_q = M_IDLE;
    pend_op     = 8'h00;
    start_ln    = line_t'(1);
    start_col   = col_t'(1);
    cur_ln      = line_t'(1);
    cur_col     = col_t'(1);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_exp_mark(logic [7:0] c);
    return c == "e" || c == "E";
  endfunction

  function automatic int op_index(logic [7:0] c);
    case (c)
      "=": return 0;
      "+": return 1;
      "-": return 2;
      "*": return 3;
      "/": return 4;
      "%": return 5;
      ">": return 6;
      "<": return 7;
      "{": return 8;
      "}": return 9;
      "[": return 10;
      "]": return 11;
      "(": return 12;
      ")": return 13;
      ".": return 14;
      ",": return 15;
      ";": return 16;
      ":": return 17;
      default: return -1;
    endcase
  endfunction

  function automatic logic [4:0] op_kind(logic [7:0] c);
    int idx;
    idx = op_index(c);
    return idx < 0 ? NO_KIND : KIND_OP_BASE + 5'(idx);
  endfunction

  function automatic logic [4:0] pair_kind(logic [7:0] c);
    case (c)
      ">": return KIND_GE;
      "<": return KIND_LE;
      "=": return KIND_EQ;
      default: return KIND_NE;
    endcase
  endfunction

  function automatic int escape_code(logic [7:0] c);
    case (c)
      "a": return 7;
      "b": return 8;
      "f": return 12;
      "n": return 10;
      "r": return 13;
      "t": return 9;
      "v": return 11;
      "\\": return 92;
      "\"": return 34;
      "?": return 63;
      "0": return 0;
      default: return -1;
    endcase
  endfunction

  // positions stick at all ones
  function automatic void step_position(logic [7:0] c);
    if (c == 8'h0A) begin
      if (cur_ln != '1) cur_ln = cur_ln + 1'b1;
      cur_col = col_t'(1);
    end else if (cur_col != '1) begin
      cur_col = cur_col + 1'b1;
    end
  endfunction

  function automatic void push_event(logic [1:0] ev, logic [4:0] kind, logic [7:0] ch,
                                     line_t ln, col_t col, logic [2:0] err);
    res_t r;
    if (step_n >= 2) return;
    r.event_res  = ev;
    r.token_kind = kind;
    r.text_char  = ch;
    r.line       = 16'(ln);
    r.column     = 16'(col);
    r.error_code = err;
    r.last       = 1'b0;
    step_ev[step_n] = r;
    step_n++;
  endfunction

  function automatic void emit_text(logic [7:0] ch);
    push_event(EV_TEXT, NO_KIND, ch, start_ln, start_col, NO_ERROR);
  endfunction

  function automatic void take_char(logic [7:0] c);
    emit_text(c);
    step_position(c);
  endfunction

  function automatic void finish_token(logic [4:0] kind);
    push_event(EV_DONE, kind, 8'h00, start_ln, start_col, NO_ERROR);
    scan_mode_q = M_IDLE;
  endfunction

  function automatic void raise_error(logic [2:0] code);
    push_event(EV_ERROR, NO_KIND, 8'h00, cur_ln, cur_col, code);
    scan_mode_q = M_ERR;
  endfunction

  function automatic void begin_token(logic [7:0] c);
    if (is_space(c)) begin
      step_position(c);
      return;
    end
    start_ln  = cur_ln;
    start_col = cur_col;
    if (is_digit(c)) begin
      take_char(c);
      scan_mode_q = M_INT;
    end else if (c == "\"") begin
      step_position(c);
      scan_mode_q = M_STR;
    end else if (is_alpha(c) || c == "_") begin
      take_char(c);
      scan_mode_q = M_NAME;
    end else if (c == "!" || op_index(c) >= 0) begin
      take_char(c);
      pend_op     = c;
      scan_mode_q = M_OP;
    end else begin
      raise_error(ERR_BAD_CHAR);
    end
  endfunction

  task automatic scan_item(input logic [7:0] c, input logic eoi);
    int code;
    int i;
    step_n = 0;
    if (eoi) begin
      case (scan_mode_q)
        M_INT:          finish_token(KIND_INT);
        M_FRAC, M_EXP:  finish_token(KIND_FLOAT);
        M_STR:          finish_token(KIND_STRING);
        M_NAME:         finish_token(KIND_NAME);
        M_FRAC0:        raise_error(ERR_BAD_FRAC);
        M_EXP0, M_EXPS: raise_error(ERR_BAD_EXP);
        M_ESC:          raise_error(ERR_ESC_AT_END);
        M_OP: begin
          if (pend_op == "!") raise_error(ERR_LONE_BANG);
          else finish_token(op_kind(pend_op));
        end
        default: ;
      endcase
      push_event(EV_DONE, KIND_END, 8'h00, cur_ln, cur_col, NO_ERROR);
      reset_scanner();
    end else begin
      case (scan_mode_q)
        M_ERR: ;
        M_STR: begin
          step_position(c);
          if (c == "\"") finish_token(KIND_STRING);
          else if (c == "\\") scan_mode_q = M_ESC;
          else emit_text(c);
        end
        M_ESC: begin
          step_position(c);
          code = escape_code(c);
          if (code < 0) begin
            raise_error(ERR_BAD_ESC);
          end else begin
            emit_text(8'(code));
            scan_mode_q = M_STR;
          end
        end
        M_INT: begin
          if (is_digit(c)) begin
            take_char(c);
          end else if (c == ".") begin
            take_char(c);
            scan_mode_q = M_FRAC0;
          end else if (is_exp_mark(c)) begin
            take_char(c);
            scan_mode_q = M_EXP0;
          end else begin
            finish_token(KIND_INT);
            begin_token(c);
          end
        end
        M_FRAC0: begin
          if (is_digit(c)) begin
            take_char(c);
            scan_mode_q = M_FRAC;
          end else begin
            raise_error(ERR_BAD_FRAC);
          end
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            take_char(c);
          end else if (is_exp_mark(c)) begin
            take_char(c);
            scan_mode_q = M_EXP0;
          end else begin
            finish_token(KIND_FLOAT);
            begin_token(c);
          end
        end
        M_EXP0: begin
          if (c == "+" || c == "-") begin
            take_char(c);
            scan_mode_q = M_EXPS;
          end else if (is_digit(c)) begin
            take_char(c);
            scan_mode_q = M_EXP;
          end else begin
            raise_error(ERR_BAD_EXP);
          end
        end
        M_EXPS: begin
          if (is_digit(c)) begin
            take_char(c);
            scan_mode_q = M_EXP;
          end else begin
            raise_error(ERR_BAD_EXP);
          end
        end
        M_EXP: begin
          if (is_digit(c)) begin
            take_char(c);
          end else begin
            finish_token(KIND_FLOAT);
            begin_token(c);
          end
        end
        M_NAME: begin
          if (is_word(c)) begin
            take_char(c);
          end else begin
            finish_token(KIND_NAME);
            begin_token(c);
          end
        end
        M_OP: begin
          if (c == "=" && (pend_op == ">" || pend_op == "<" || pend_op == "=" ||
                           pend_op == "!")) begin
            take_char(c);
            finish_token(pair_kind(pend_op));
          end else if (pend_op == "!") begin
            raise_error(ERR_LONE_BANG);
          end else begin
            finish_token(op_kind(pend_op));
            begin_token(c);
          end
        end
        default: begin
          scan_mode_q = M_IDLE;
          begin_token(c);
        end
      endcase
    end
    if (step_n > 0) step_ev[step_n-1].last = 1'b1;
    for (i = 0; i < step_n; i++) token_events_due = {token_events_due, step_ev[i]};
  endtask

  task automatic report_mismatch(input string what);
    fault_total++;
    $display("mismatch: %s", what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("event %0d %s: got %0h, expected %0h",
                                events_seen, name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_scanner();
      token_events_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        scan_item(in_mon.char_code, in_mon.end_of_input);
      if (out_mon.valid && out_mon.ready) begin
        events_seen++;
        if (token_events_due.size() == 0) begin
          report_mismatch($sformatf("event %0d arrived with none expected", events_seen));
        end else begin
          head_event = token_events_due.pop_front();
          check_field("event_res",  16'(out_mon.event_res),  16'(head_event.event_res));
          check_field("token_kind", 16'(out_mon.token_kind), 16'(head_event.token_kind));
          check_field("text_char",  16'(out_mon.text_char),  16'(head_event.text_char));
          check_field("line",       out_mon.line,            head_event.line);
          check_field("column",     out_mon.column,          head_event.column);
          check_field("error_code", 16'(out_mon.error_code), 16'(head_event.error_code));
          check_field("last",       16'(out_mon.last),       16'(head_event.last));
        end
      end
    end
    mismatch_count <= fault_total;
    pending_events <= token_events_due.size();
  end

endmodule

### sim/tb_source_char_tokenizer.sv
// ---------------------------------------------------------------------------
// tb_source_char_tokenizer
// Feeds the tokenizer short directed programs and random programs of mostly
// well-formed tokens with some broken ones and stray bytes, under several
// idling patterns on both channels. The checker beside the block does all
// checking.
// ---------------------------------------------------------------------------
module tb_source_char_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int END_SETTLE   = 16;
  localparam int PHASE_ITEMS  = 275;

  logic clk;
  logic rst_n;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int pending;
  int cycle_count = 0;
  int items_sent;

  logic [7:0] src_text [$];
  logic [7:0] esc_letters [11] = '{"a", "b", "f", "n", "r", "t", "v", "\\", "\"", "?", "0"};
  logic [7:0] op_chars [18] = '{"=", "+", "-", "*", "/", "%", ">", "<", "{", "}",
                                "[", "]", "(", ")", ".", ",", ";", ":"};
  logic [7:0] pair_lead [4] = '{">", "<", "=", "!"};

  sct_in_if  src_ch ();
  sct_out_if evt_ch ();

  source_char_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (src_ch),
    .out_ch (evt_ch)
  );

  sct_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (src_ch),
    .out_mon        (evt_ch),
    .mismatch_count (mismatches),
    .pending_events (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    evt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("source_char_tokenizer regression: fail");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      src_ch.valid <= 1'b0;
      @(posedge clk);
    end
    src_ch.valid        <= 1'b1;
    src_ch.char_code    <= c;
    src_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!src_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // plays the queued text, then the end marker with a junk byte
  task automatic send_program();
    foreach (src_text[i]) send_item(src_text[i], 1'b0);
    src_text.delete();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic drain();
    src_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic add_byte(input logic [7:0] b);
    src_text = {src_text, b};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_digits(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) add_byte(8'h30 + 8'($urandom_range(9)));
  endtask

  // letters first, then underscore, then digits
  function automatic logic [7:0] rand_word_char(input bit lead);
    int r;
    r = $urandom_range(lead ? 52 : 62);
    if (r < 26) return 8'h41 + 8'(r);
    if (r < 52) return 8'h61 + 8'(r - 26);
    if (r == 52) return "_";
    return 8'h30 + 8'(r - 53);
  endfunction

  task automatic add_string();
    logic [7:0] b;
    add_byte("\"");
    repeat ($urandom_range(5)) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          add_byte("\\");
          add_byte(esc_letters[$urandom_range(10)]);
        end
        3: begin
          b = 8'($urandom_range(255));
          add_byte((b == "\"" || b == "\\") ? 8'h00 : b);
        end
        default: begin
          b = 8'($urandom_range(126, 32));
          add_byte((b == "\"" || b == "\\") ? "x" : b);
        end
      endcase
    end
    if ($urandom_range(9) != 0) add_byte("\"");
  endtask

  task automatic add_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 14) begin
      add_digits(1, 4);
    end else if (pick < 27) begin
      add_digits(1, 3);
      if ($urandom_range(1)) begin
        add_byte(".");
        add_digits(1, 3);
      end
      if ($urandom_range(1)) begin
        add_byte($urandom_range(1) ? "e" : "E");
        case ($urandom_range(2))
          1: add_byte("+");
          2: add_byte("-");
          default: ;
        endcase
        add_digits(1, 2);
      end
    end else if (pick < 42) begin
      add_string();
    end else if (pick < 57) begin
      add_byte(rand_word_char(1'b1));
      repeat ($urandom_range(5)) add_byte(rand_word_char(1'b0));
    end else if (pick < 78) begin
      if ($urandom_range(9) < 3) begin
        add_byte(pair_lead[$urandom_range(3)]);
        add_byte("=");
      end else begin
        add_byte(op_chars[$urandom_range(17)]);
      end
    end else if (pick < 94) begin
      case ($urandom_range(3))
        0: add_byte(" ");
        1: add_byte(8'h0A);
        2: add_byte(8'($urandom_range(13, 9)));
        default: add_text("  ");
      endcase
    end else if (pick < 98) begin
      case ($urandom_range(4))
        0: add_text("1.x");
        1: add_text("2e;");
        2: add_text("3E-a");
        3: add_text("!?");
        default: add_text("\"\\q");
      endcase
    end else begin
      add_byte(8'($urandom_range(255)));
    end
    if ($urandom_range(9) < 6) add_byte(" ");
  endtask

  task automatic random_phase(input int idle, input int stall);
    int first;
    send_idle_pct = idle;
    recv_stall_pct <= stall;
    first = items_sent;
    while (items_sent - first < PHASE_ITEMS) begin
      repeat ($urandom_range(20, 3)) add_token();
      send_program();
      if ($urandom_range(4) == 0) drain();
    end
    drain();
  endtask

  initial begin
    rst_n               = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    items_sent          = 0;
    src_ch.valid        = 1'b0;
    src_ch.char_code    = 8'h00;
    src_ch.end_of_input = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // float, paired op, name; then a bare fraction, a lone bang, an escape and a string cut short, and a bad byte
    add_text("9.5e-1<=_z");
    send_program();
    add_text("1.");
    send_program();
    add_text("!x");
    send_program();
    add_text("\"\\");
    send_program();
    add_text("\"a");
    send_program();
    add_byte(8'hFF);
    send_program();
    drain();

    random_phase(0, 0);
    random_phase(60, 0);
    random_phase(0, 60);
    random_phase(6, 6);

    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("source_char_tokenizer regression: pass");
    end else begin
      $display("source_char_tokenizer regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/sct_pkg.sv
rtl/sct_in_if.sv
rtl/sct_out_if.sv
rtl/sct_step.sv
rtl/source_char_tokenizer.sv
sim/sct_checker.sv
sim/tb_source_char_tokenizer.sv
